/* hw/rtl/code_point_range_lookup_defines.svh */
// Assertion macros used by the checker file cprl_checker.sv.
`ifndef CODE_POINT_RANGE_LOOKUP_DEFINES_SVH
`define CODE_POINT_RANGE_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CPRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CPRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cprl_pkg.sv */
package cprl_pkg;

	localparam int MAX_RANGES = 256;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int CP_W       = 21;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_IN_RANGE = 2'd0;
	localparam logic [1:0] STATUS_NO_RANGE = 2'd1;
	localparam logic [1:0] STATUS_LOADED   = 2'd2;
	localparam logic [1:0] STATUS_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]      func;
		logic [CP_W-1:0] code_point;
		logic [CP_W-1:0] range_last;
		logic            has_fonts;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] block_index;
		logic       from_cache;
		logic       default_added;
	} result_t;

	typedef struct packed {
		logic [CP_W-1:0] first;
		logic [CP_W-1:0] final_cp;
		logic            filled;
	} entry_t;

endpackage

/* hw/rtl/code_point_range_lookup.sv */
// Code-point range table with binary search and a one-entry last-hit cache.
// Input: a word is taken at a rising edge with start high and busy low; cmd.func
//   selects append (store a range at the next free slot), query or clear.
//   Ranges must be appended in ascending order of start; the block does not check it.
// Output: done is high for exactly one cycle with the result word on result;
//   the receiver takes it at that edge and cannot hold it off.
// Sequence: append and clear show their result in the cycle after the accept,
//   as does a query on an empty table. A query with a valid cache entry first
//   checks that entry in ST_CACHE, and a cache hit answers from there. A search
//   runs one bisection step per cycle (up to log2(MAX_RANGES)+1 steps) and then
//   checks the chosen entry in ST_FINAL.
// Throughput: one word at a time; busy stays high through cache check, search
//   and final check. The table RAM's single read port, one read per bisection step, sets this.
// Reset: entry count and cache valid clear at once; the table RAM keeps no
//   reset and only slots below the count are ever read. A func of three is
//   taken and dropped with no result.
module code_point_range_lookup
	import cprl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CACHE  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_FINAL  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [CP_W-1:0]  cp_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] cached_index_q, cached_index_d;
	logic             cache_valid_q, cache_valid_d;
	logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0] mid_q, mid_d;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, rd;
	logic [$bits(entry_t)-1:0] ram_rdata;

	logic             accept;
	logic             hit;
	logic             le;
	logic [CNT_W-1:0] lo_n, hi_n, mid_n, mid0;
	logic [CNT_W-1:0] pick;

	assign accept = start && (state_q == ST_IDLE);
	assign rd     = entry_t'(ram_rdata);
	assign hit    = (rd.first <= cp_q) && (rd.final_cp >= cp_q);
	assign mid0   = count_q >> 1;

	// one bisection step on the entry just read at mid_q
	assign le    = rd.first <= cp_q;
	assign lo_n  = le ? CNT_W'(mid_q) + CNT_W'(1) : lo_q;
	assign hi_n  = le ? hi_q : CNT_W'(mid_q);
	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);
	assign pick  = (lo_n == '0) ? '0 : lo_n - CNT_W'(1);

	// Writes occur only at an append accept or in ST_FINAL, and no read is
	// issued in either cycle, so no read can meet a write to the same slot.
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		cached_index_d = cached_index_q;
		cache_valid_d  = cache_valid_q;
		lo_d           = lo_q;
		hi_d           = hi_q;
		mid_d          = mid_q;
		done_d         = 1'b0;
		result_d       = result_q;
		ram_we         = 1'b0;
		ram_waddr      = count_q[IDX_W-1:0];
		ram_wdata      = '{first: cmd.code_point, final_cp: cmd.range_last,
		                   filled: cmd.has_fonts};
		ram_re         = 1'b0;
		ram_raddr      = mid0[IDX_W-1:0];

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FUNC_APPEND: begin
							done_d = 1'b1;
							if (count_q == CNT_W'(MAX_RANGES)) begin
								result_d = '{status: STATUS_FULL, default: '0};
							end else begin
								ram_we   = 1'b1;
								count_d  = count_q + CNT_W'(1);
								result_d = '{status: STATUS_LOADED,
								             block_index: 8'(count_q),
								             default: '0};
							end
						end
						FUNC_QUERY: begin
							if (cache_valid_q && (CNT_W'(cached_index_q) < count_q)) begin
								ram_re    = 1'b1;
								ram_raddr = cached_index_q;
								state_d   = ST_CACHE;
							end else if (count_q == '0) begin
								done_d   = 1'b1;
								result_d = '{status: STATUS_NO_RANGE, default: '0};
							end else begin
								ram_re  = 1'b1;
								lo_d    = '0;
								hi_d    = count_q;
								mid_d   = mid0[IDX_W-1:0];
								state_d = ST_SEARCH;
							end
						end
						FUNC_CLEAR: begin
							count_d        = '0;
							cached_index_d = '0;
							cache_valid_d  = 1'b0;
							done_d         = 1'b1;
							result_d       = '{status: STATUS_LOADED, default: '0};
						end
						default: begin
						end
					endcase
				end
			end
			ST_CACHE: begin
				if (hit) begin
					done_d   = 1'b1;
					result_d = '{status: STATUS_IN_RANGE,
					             block_index: 8'(cached_index_q),
					             from_cache: 1'b1, default_added: 1'b0};
					state_d  = ST_IDLE;
				end else begin
					ram_re  = 1'b1;
					lo_d    = '0;
					hi_d    = count_q;
					mid_d   = mid0[IDX_W-1:0];
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				ram_re = 1'b1;
				lo_d   = lo_n;
				hi_d   = hi_n;
				if (lo_n < hi_n) begin
					ram_raddr = mid_n[IDX_W-1:0];
					mid_d     = mid_n[IDX_W-1:0];
				end else begin
					// settle on the last start not above the code point
					ram_raddr      = pick[IDX_W-1:0];
					mid_d          = pick[IDX_W-1:0];
					cached_index_d = pick[IDX_W-1:0];
					cache_valid_d  = 1'b1;
					state_d        = ST_FINAL;
				end
			end
			ST_FINAL: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				if (hit) begin
					result_d = '{status: STATUS_IN_RANGE, block_index: 8'(mid_q),
					             from_cache: 1'b0, default_added: !rd.filled};
					if (!rd.filled) begin
						ram_we    = 1'b1;
						ram_waddr = mid_q;
						ram_wdata = '{first: rd.first, final_cp: rd.final_cp,
						              filled: 1'b1};
					end
				end else begin
					result_d = '{status: STATUS_NO_RANGE, default: '0};
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			cached_index_q <= '0;
			cache_valid_q  <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			cached_index_q <= cached_index_d;
			cache_valid_q  <= cache_valid_d;
			done_q         <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q <= cmd.code_point;
		end
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		result_q <= result_d;
	end

	cprl_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* hw/rtl/cprl_ram.sv */
module cprl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/cprl_checker.sv */
`include "code_point_range_lookup_defines.svh"

module cprl_checker
	import cprl_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input cmd_t    cmd,
	input logic    busy,
	input logic    done,
	input result_t result
);

	logic accept;
	logic quiet_status;

	assign accept       = start && !busy;
	assign quiet_status = (result.status == STATUS_NO_RANGE) ||
	                      (result.status == STATUS_FULL);

	// a word only shows after an accept or while work was under way
	`CPRL_ASSERT_NOW(a_done_has_cause, done, $past(busy) || $past(accept), "result word without cause")

	// append and clear answer in the very next cycle
	`CPRL_ASSERT_NEXT(a_table_op_next, accept && ((cmd.func == FUNC_APPEND) || (cmd.func == FUNC_CLEAR)), done && ((result.status == STATUS_LOADED) || (result.status == STATUS_FULL)), "append or clear result missing")

	// a query either answers at once or keeps the block busy
	`CPRL_ASSERT_NEXT(a_query_progress, accept && (cmd.func == FUNC_QUERY), busy || done, "query dropped")

	`CPRL_ASSERT_NOW(a_cache_hit_clean, done && result.from_cache, (result.status == STATUS_IN_RANGE) && !result.default_added, "cache hit result malformed")

	`CPRL_ASSERT_NOW(a_quiet_zero, done && quiet_status, (result.block_index == 8'd0) && !result.from_cache && !result.default_added, "no-range or full result carries data")

endmodule

bind code_point_range_lookup cprl_checker u_cprl_checker (.*);
